// File: design/dfa_longest_match_scanner_defines.svh
// Assertion macros shared by the DFA scanner checkers.
// Depends on nothing; the including module provides aclk and aresetn.
`ifndef DFA_LONGEST_MATCH_SCANNER_DEFINES_SVH
`define DFA_LONGEST_MATCH_SCANNER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define DLMS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define DLMS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

// Delayed implication, disabled during reset
`define DLMS_ASSERT_DLY3(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> ##3 (cons)) else $error(msg);

`endif

// File: design/dlms_pkg.sv
// Package for the DFA longest-match scanner: payload structs, codes, defaults.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dlms_pkg;

    localparam int NUM_STATES_DEF = 256;
    localparam int LEN_BITS_DEF   = 16;
    localparam int TYPE_BITS_DEF  = 16;
    localparam int ALPHABET       = 256;

    localparam logic [7:0] START_STATE_RST = 8'd1;
    localparam logic [8:0] TYPE_COLUMN     = 9'd256;

    // Transaction kinds on the input channel
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_SCAN = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [7:0]  sym_byte;
        logic        end_of_string;
        logic [7:0]  entry_state;
        logic [8:0]  entry_column;
        logic [15:0] entry_value;
    } dlms_in_t;

    typedef struct packed {
        logic        matched;
        logic [15:0] match_length;
        logic [15:0] token_type;
    } dlms_out_t;

endpackage

`default_nettype wire

// File: design/dfa_longest_match_scanner.sv
// Top level of the table-driven DFA longest-match scanner.
// Depends on dlms_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   s_* channel (valid/ready) carries one transaction per byte or table write.
//   mode = load writes next_table[entry_state][entry_column] (column 0..255)
//   or the token type of entry_state (column 256); out-of-range rows and
//   columns are dropped. mode = scan steps the DFA by sym_byte; the scan
//   transaction with end_of_string set produces one m_* transaction with
//   matched, match_length and token_type, then restarts from start_state.
//   cfg_wr_en/cfg_wr_data write start_state; write only while idle.
// Throughput and result path
//   One transaction per cycle while s_ready is high. The next-state memory
//   read is issued in the accept cycle with the address built from the
//   state that the previous byte's read just returned, so the loop through
//   that one memory port sets the rate. An end-of-string result passes the
//   next-state read, the type read and the output register to m_valid.
// Reset
//   aresetn (synchronous, active low) clears the pipeline and scan state and
//   sets start_state to 1. Table contents are undefined until written.
// Backpressure
//   A result waits in the output register; one more finished result goes to
//   a skid register, after which s_ready drops and the pipeline holds.
module dfa_longest_match_scanner
    import dlms_pkg::*;
#(
    parameter int NUM_STATES = NUM_STATES_DEF,
    parameter int LEN_BITS   = LEN_BITS_DEF,
    parameter int TYPE_BITS  = TYPE_BITS_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire dlms_in_t   s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output dlms_out_t       m_data,
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data
);

    localparam int ROW_BITS  = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
    localparam int ADDR_BITS = ROW_BITS + 8;
    localparam int TBL_DEPTH = NUM_STATES * ALPHABET;

    // Map an 8-bit state onto a table row index
    function automatic logic [ROW_BITS-1:0] row_of(input logic [7:0] st);
        logic [ROW_BITS+7:0] ext;
        ext = (ROW_BITS+8)'(st);
        return ext[ROW_BITS-1:0];
    endfunction

    function automatic logic in_rng(input logic [7:0] st);
        return {24'd0, st} < 32'(NUM_STATES);
    endfunction

    function automatic logic [15:0] len_to16(input logic [LEN_BITS-1:0] v);
        logic [LEN_BITS+15:0] ext;
        ext = (LEN_BITS+16)'(v);
        return ext[15:0];
    endfunction

    function automatic logic [15:0] type_to16(input logic [TYPE_BITS-1:0] v);
        logic [TYPE_BITS+15:0] ext;
        ext = (TYPE_BITS+16)'(v);
        return ext[15:0];
    endfunction

    // Table memories: next state per (state, byte), token type per state
    logic [7:0]           nt_mem [0:TBL_DEPTH-1];
    logic [TYPE_BITS-1:0] ty_mem [0:NUM_STATES-1];

    // Architectural scan state
    logic [7:0]          start_reg,    start_next;
    logic [7:0]          cur_reg,      cur_next;
    logic                dead_reg,     dead_next;
    logic [LEN_BITS-1:0] pos_reg,      pos_next;
    logic                found_reg,    found_next;
    logic [LEN_BITS-1:0] best_len_reg, best_len_next;
    logic [TYPE_BITS-1:0] best_type_reg, best_type_next;

    // Stage B: next-state read data is valid
    logic       b_valid_reg;
    logic       b_live_reg;
    logic       b_oor_reg;
    logic       b_eos_reg;
    logic [7:0] nt_rdata_reg;

    // Stage C: token-type read data is valid
    logic                 c_valid_reg;
    logic                 c_check_reg,  c_check_next;
    logic                 c_eos_reg;
    logic [LEN_BITS-1:0]  c_len_reg,    step_pos;
    logic [TYPE_BITS-1:0] ty_rdata_reg;

    // Output register and skid
    logic      out_valid_reg;
    dlms_out_t out_data_reg;
    logic      skid_valid_reg;
    dlms_out_t skid_data_reg;

    logic      adv;
    logic      in_acc;
    logic [7:0] nxt_state;
    logic      step_on;
    logic      hit;
    logic      res_valid;
    dlms_out_t res_data;
    logic [ADDR_BITS-1:0] nt_raddr;
    logic [ADDR_BITS-1:0] nt_waddr;
    logic      nt_we;
    logic      ty_we;
    logic [TYPE_BITS+15:0] wr_type_ext;

    // Pipeline advances whenever the skid register is free
    assign adv     = !skid_valid_reg;
    assign s_ready = adv;
    assign in_acc  = s_valid && adv;

    // ---------------- Stage B: commit the DFA step ----------------
    assign nxt_state = b_oor_reg ? 8'd0 : nt_rdata_reg;
    assign step_on   = b_valid_reg && b_live_reg;

    always_comb begin
        cur_next     = cur_reg;
        dead_next    = dead_reg;
        step_pos     = pos_reg;
        c_check_next = 1'b0;
        if (step_on) begin
            cur_next = nxt_state;
            if (nxt_state == 8'd0) begin
                dead_next = 1'b1;
            end else begin
                if (!(&pos_reg)) begin
                    step_pos = pos_reg + LEN_BITS'(1);
                end
                c_check_next = in_rng(nxt_state);
            end
        end
        pos_next = step_pos;
        // End of string: restart scan for the following transaction
        if (b_valid_reg && b_eos_reg) begin
            cur_next  = start_reg;
            dead_next = 1'b0;
            pos_next  = '0;
        end
        // Start-state write reloads a scan that has not consumed a byte yet
        start_next = start_reg;
        if (cfg_wr_en) begin
            start_next = cfg_wr_data;
            if (pos_reg == '0 && !dead_reg) begin
                cur_next = cfg_wr_data;
            end
        end
    end

    // ---------------- Stage A: issue the next-state read ----------------
    // The address uses the state just produced by stage B (forwarded).
    assign nt_raddr = {row_of(cur_next), s_data.sym_byte};

    assign nt_we    = in_acc && (s_data.mode == MODE_LOAD) && in_rng(s_data.entry_state)
                      && !s_data.entry_column[8];
    assign ty_we    = in_acc && (s_data.mode == MODE_LOAD) && in_rng(s_data.entry_state)
                      && (s_data.entry_column == TYPE_COLUMN);
    assign nt_waddr = {row_of(s_data.entry_state), s_data.entry_column[7:0]};
    assign wr_type_ext = (TYPE_BITS+16)'(s_data.entry_value);

    // Writes land at accept, so a later byte sees them; a same-edge type read
    // from an earlier byte returns the old value.
    always_ff @(posedge aclk) begin
        if (nt_we) begin
            nt_mem[nt_waddr] <= s_data.entry_value[7:0];
        end
        if (adv) begin
            nt_rdata_reg <= nt_mem[nt_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ty_we) begin
            ty_mem[row_of(s_data.entry_state)] <= wr_type_ext[TYPE_BITS-1:0];
        end
        if (adv) begin
            ty_rdata_reg <= ty_mem[row_of(nxt_state)];
        end
    end

    // ---------------- Stage C: track the longest accepted prefix ----------------
    assign hit = c_valid_reg && c_check_reg && (ty_rdata_reg != '0);

    always_comb begin
        found_next     = found_reg;
        best_len_next  = best_len_reg;
        best_type_next = best_type_reg;
        if (hit) begin
            found_next     = 1'b1;
            best_len_next  = c_len_reg;
            best_type_next = ty_rdata_reg;
        end
        res_data.matched      = found_next;
        res_data.match_length = found_next ? len_to16(best_len_next) : 16'd0;
        res_data.token_type   = found_next ? type_to16(best_type_next) : 16'd0;
        if (c_valid_reg && c_eos_reg) begin
            found_next     = 1'b0;
            best_len_next  = '0;
            best_type_next = '0;
        end
    end

    assign res_valid = c_valid_reg && c_eos_reg && adv;

    // ---------------- Control and state registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg     <= START_STATE_RST;
            cur_reg       <= START_STATE_RST;
            dead_reg      <= 1'b0;
            pos_reg       <= '0;
            found_reg     <= 1'b0;
            best_len_reg  <= '0;
            best_type_reg <= '0;
            b_valid_reg   <= 1'b0;
            b_live_reg    <= 1'b0;
            b_oor_reg     <= 1'b0;
            b_eos_reg     <= 1'b0;
            c_valid_reg   <= 1'b0;
            c_check_reg   <= 1'b0;
            c_eos_reg     <= 1'b0;
        end else begin
            start_reg <= start_next;
            if (adv) begin
                cur_reg       <= cur_next;
                dead_reg      <= dead_next;
                pos_reg       <= pos_next;
                found_reg     <= found_next;
                best_len_reg  <= best_len_next;
                best_type_reg <= best_type_next;
                b_valid_reg   <= in_acc && (s_data.mode == MODE_SCAN);
                b_live_reg    <= !dead_next;
                b_oor_reg     <= !in_rng(cur_next);
                b_eos_reg     <= s_data.end_of_string;
                c_valid_reg   <= b_valid_reg;
                c_check_reg   <= c_check_next;
                c_eos_reg     <= b_eos_reg;
            end
        end
    end

    // Prefix length travels with the step into stage C
    always_ff @(posedge aclk) begin
        if (adv) begin
            c_len_reg <= step_pos;
        end
    end

    // ---------------- Output register with skid ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= res_valid;
            end
        end else if (res_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res_data;
        end else if (res_valid) begin
            skid_data_reg <= res_data;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire

// File: design/dlms_checker.sv
// Port-level checker for the DFA scanner, bound to the top level.
// Depends on dlms_pkg and dfa_longest_match_scanner_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "dfa_longest_match_scanner_defines.svh"

module dlms_checker
    import dlms_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire dlms_in_t  s_data,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire dlms_out_t m_data
);

    // A stalled result transaction holds its value
    `DLMS_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")

    // No match reports zero length and zero type
    `DLMS_ASSERT_IMP(a_nomatch_zero, m_valid && !m_data.matched, (m_data.match_length == 16'd0) && (m_data.token_type == 16'd0), "unmatched result carries data")

    // Input side stalls only behind a waiting result
    `DLMS_ASSERT_IMP(a_stall_cause, !s_ready, m_valid, "input stalled with empty output")

    // From an empty output, an accepted end of string raises m_valid after the read stages and output register
    `DLMS_ASSERT_DLY3(a_eos_latency, s_valid && s_ready && !m_valid && (s_data.mode == MODE_SCAN) && s_data.end_of_string, m_valid, "end-of-string result missing")

endmodule

bind dfa_longest_match_scanner dlms_checker u_dlms_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
